// ===== hdl/ffha_pkg.sv =====
package ffha_pkg;

    localparam logic       CMD_ALLOC   = 1'b0;
    localparam logic       CMD_FREE    = 1'b1;
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
    localparam logic       REG_BASE    = 1'b0;
    localparam logic       REG_SIZE    = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] request_bytes;
        logic [31:0] block_address;
    } t_in_word;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_UP_RD, S_UP_WR, S_SPLIT_NEW, S_SPLIT_OWN,
        S_ALLOC_WHOLE, S_PREV_RD, S_PREV_CHK, S_NEXT_RD, S_NEXT_CHK, S_DN_RD, S_DN_WR,
        S_REL_WR, S_DONE
    } t_state;

    typedef enum logic [2:0] {RD_IDX, RD_IDX_M1, RD_IDX_P1, RD_J_M1, RD_J_P1} t_rd_sel;
    typedef enum logic [2:0] {
        WR_NONE, WR_SHIFT, WR_SPLIT_NEW, WR_SPLIT_OWN, WR_WHOLE, WR_FREE
    } t_wr_sel;
    typedef enum logic [1:0] {IDX_HOLD, IDX_INC, IDX_DEC} t_idx_op;
    typedef enum logic [2:0] {J_HOLD, J_CNT, J_IDX, J_IDX_P1, J_INC, J_DEC} t_j_op;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} t_cnt_op;
    typedef enum logic [1:0] {CUR_HOLD, CUR_LOAD, CUR_MERGE_PREV, CUR_MERGE_NEXT} t_cur_op;
    typedef enum logic [1:0] {RES_HOLD, RES_GRANT, RES_MISS, RES_OK} t_res_op;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_idx_op idx_op;
        t_j_op   j_op;
        t_cnt_op cnt_op;
        t_cur_op cur_op;
        t_res_op res_op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free_cmd;
        logic idx_end;
        logic hit;
        logic split_ok;
        logic idx_zero;
        logic next_in;
        logic up_more;
        logic dn_more;
        logic rd_free;
    } t_dp_stat;

endpackage

// ===== hdl/ffha_ctrl.sv =====
module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ffha_pkg::t_dp_stat i_stat,
    output ffha_pkg::t_dp_cmd o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    ffha_pkg::t_state r_state, n_state;
    logic             r_after_next, n_after_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ffha_pkg::S_IDLE;
            r_after_next <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_after_next <= n_after_next;
        end
    end

    // next state
    always_comb begin
        n_state      = r_state;
        n_after_next = r_after_next;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                if (i_start) n_state = ffha_pkg::S_SCAN_RD;
            end
            ffha_pkg::S_SCAN_RD: begin
                n_state = i_stat.idx_end ? ffha_pkg::S_DONE : ffha_pkg::S_SCAN_CHK;
            end
            ffha_pkg::S_SCAN_CHK: begin
                if (!i_stat.hit) n_state = ffha_pkg::S_SCAN_RD;
                else if (i_stat.is_free_cmd) n_state = ffha_pkg::S_PREV_RD;
                else if (i_stat.split_ok) n_state = ffha_pkg::S_UP_RD;
                else n_state = ffha_pkg::S_ALLOC_WHOLE;
            end
            ffha_pkg::S_UP_RD: begin
                n_state = i_stat.up_more ? ffha_pkg::S_UP_WR : ffha_pkg::S_SPLIT_NEW;
            end
            ffha_pkg::S_UP_WR:       n_state = ffha_pkg::S_UP_RD;
            ffha_pkg::S_SPLIT_NEW:   n_state = ffha_pkg::S_SPLIT_OWN;
            ffha_pkg::S_SPLIT_OWN:   n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_ALLOC_WHOLE: n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_PREV_RD: begin
                n_state = i_stat.idx_zero ? ffha_pkg::S_NEXT_RD : ffha_pkg::S_PREV_CHK;
            end
            ffha_pkg::S_PREV_CHK: begin
                if (i_stat.rd_free) begin
                    n_state      = ffha_pkg::S_DN_RD;
                    n_after_next = 1'b0;
                end else begin
                    n_state = ffha_pkg::S_NEXT_RD;
                end
            end
            ffha_pkg::S_NEXT_RD: begin
                n_state = i_stat.next_in ? ffha_pkg::S_NEXT_CHK : ffha_pkg::S_REL_WR;
            end
            ffha_pkg::S_NEXT_CHK: begin
                if (i_stat.rd_free) begin
                    n_state      = ffha_pkg::S_DN_RD;
                    n_after_next = 1'b1;
                end else begin
                    n_state = ffha_pkg::S_REL_WR;
                end
            end
            ffha_pkg::S_DN_RD: begin
                if (i_stat.dn_more) n_state = ffha_pkg::S_DN_WR;
                else n_state = r_after_next ? ffha_pkg::S_REL_WR : ffha_pkg::S_NEXT_RD;
            end
            ffha_pkg::S_DN_WR:  n_state = ffha_pkg::S_DN_RD;
            ffha_pkg::S_REL_WR: n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_DONE:   n_state = ffha_pkg::S_IDLE;
            default:            n_state = ffha_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = ffha_pkg::RD_IDX;
        o_cmd.wr_sel = ffha_pkg::WR_NONE;
        o_cmd.idx_op = ffha_pkg::IDX_HOLD;
        o_cmd.j_op   = ffha_pkg::J_HOLD;
        o_cmd.cnt_op = ffha_pkg::CNT_HOLD;
        o_cmd.cur_op = ffha_pkg::CUR_HOLD;
        o_cmd.res_op = ffha_pkg::RES_HOLD;
        case (r_state)
            ffha_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            ffha_pkg::S_SCAN_RD: begin
                if (i_stat.idx_end) o_cmd.res_op = ffha_pkg::RES_MISS;
                else o_cmd.rd_en = 1'b1;
            end
            ffha_pkg::S_SCAN_CHK: begin
                if (i_stat.hit) begin
                    o_cmd.cur_op = ffha_pkg::CUR_LOAD;
                    o_cmd.j_op   = ffha_pkg::J_CNT;
                end else begin
                    o_cmd.idx_op = ffha_pkg::IDX_INC;
                end
            end
            ffha_pkg::S_UP_RD: begin
                o_cmd.rd_en  = i_stat.up_more;
                o_cmd.rd_sel = ffha_pkg::RD_J_M1;
            end
            ffha_pkg::S_UP_WR: begin
                o_cmd.wr_sel = ffha_pkg::WR_SHIFT;
                o_cmd.j_op   = ffha_pkg::J_DEC;
            end
            ffha_pkg::S_SPLIT_NEW: begin
                o_cmd.wr_sel = ffha_pkg::WR_SPLIT_NEW;
                o_cmd.cnt_op = ffha_pkg::CNT_INC;
            end
            ffha_pkg::S_SPLIT_OWN: begin
                o_cmd.wr_sel = ffha_pkg::WR_SPLIT_OWN;
                o_cmd.res_op = ffha_pkg::RES_GRANT;
            end
            ffha_pkg::S_ALLOC_WHOLE: begin
                o_cmd.wr_sel = ffha_pkg::WR_WHOLE;
                o_cmd.res_op = ffha_pkg::RES_GRANT;
            end
            ffha_pkg::S_PREV_RD: begin
                o_cmd.rd_en  = !i_stat.idx_zero;
                o_cmd.rd_sel = ffha_pkg::RD_IDX_M1;
            end
            ffha_pkg::S_PREV_CHK: begin
                if (i_stat.rd_free) begin
                    o_cmd.cur_op = ffha_pkg::CUR_MERGE_PREV;
                    o_cmd.j_op   = ffha_pkg::J_IDX;
                    o_cmd.idx_op = ffha_pkg::IDX_DEC;
                end
            end
            ffha_pkg::S_NEXT_RD: begin
                o_cmd.rd_en  = i_stat.next_in;
                o_cmd.rd_sel = ffha_pkg::RD_IDX_P1;
            end
            ffha_pkg::S_NEXT_CHK: begin
                if (i_stat.rd_free) begin
                    o_cmd.cur_op = ffha_pkg::CUR_MERGE_NEXT;
                    o_cmd.j_op   = ffha_pkg::J_IDX_P1;
                end
            end
            ffha_pkg::S_DN_RD: begin
                o_cmd.rd_en  = i_stat.dn_more;
                o_cmd.rd_sel = ffha_pkg::RD_J_P1;
                if (!i_stat.dn_more) o_cmd.cnt_op = ffha_pkg::CNT_DEC;
            end
            ffha_pkg::S_DN_WR: begin
                o_cmd.wr_sel = ffha_pkg::WR_SHIFT;
                o_cmd.j_op   = ffha_pkg::J_INC;
            end
            ffha_pkg::S_REL_WR: begin
                o_cmd.wr_sel = ffha_pkg::WR_FREE;
                o_cmd.res_op = ffha_pkg::RES_OK;
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != ffha_pkg::S_IDLE);
    assign o_done = (r_state == ffha_pkg::S_DONE);

endmodule

// ===== hdl/ffha_dp.sv =====
module ffha_dp #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 16,
    parameter int ADDR_BITS    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ffha_pkg::t_in_word  i_in,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  ffha_pkg::t_dp_cmd   i_cmd,
    output ffha_pkg::t_dp_stat  o_stat,
    output ffha_pkg::t_out_word o_out
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int A     = ADDR_BITS;
    localparam int W     = A + 33;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
    localparam logic [31:0]      HDR32   = 32'(HEADER_BYTES);
    localparam logic [A-1:0]     HDRA    = A'(HEADER_BYTES);
    localparam logic [33:0]      HDR34P1 = 34'(HEADER_BYTES) + 34'd1;

    logic [W-1:0]     r_mem [MAX_SEGMENTS];
    logic [W-1:0]     r_rdata;
    logic [31:0]      r_base, r_size;
    logic [CNT_W-1:0] r_cnt, r_idx, r_j;
    logic             r_cmd;
    logic [31:0]      r_req, r_addr;
    logic [A-1:0]     r_cur_start;
    logic [31:0]      r_cur_bytes;
    ffha_pkg::t_out_word r_out;

    logic [A-1:0]     rd_start;
    logic [31:0]      rd_bytes;
    logic             rd_used;
    logic [A+31:0]    req_ext, addr_ext, base_ext, pay_ext;
    logic [A-1:0]     req_a, addr_a, cur_pay, rd_pay;
    logic [31:0]      n_base, n_size;
    logic [CNT_W-1:0] idx_m1, idx_p1, j_m1, j_p1;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    logic [W-1:0]     wr_data;

    assign rd_start = r_rdata[A-1:0];
    assign rd_bytes = r_rdata[A+31:A];
    assign rd_used  = r_rdata[A+32];

    assign req_ext  = {{A{1'b0}}, r_req};
    assign addr_ext = {{A{1'b0}}, r_addr};
    assign req_a    = req_ext[A-1:0];
    assign addr_a   = addr_ext[A-1:0];
    assign rd_pay   = rd_start + HDRA;
    assign cur_pay  = r_cur_start + HDRA;
    assign pay_ext  = {32'b0, cur_pay};

    assign idx_m1 = r_idx - CNT_W'(1);
    assign idx_p1 = r_idx + CNT_W'(1);
    assign j_m1   = r_j - CNT_W'(1);
    assign j_p1   = r_j + CNT_W'(1);

    // status towards the controller
    always_comb begin
        o_stat.is_free_cmd = (r_cmd == ffha_pkg::CMD_FREE);
        o_stat.idx_end     = (r_idx >= r_cnt);
        o_stat.hit         = (r_cmd == ffha_pkg::CMD_FREE) ? (rd_used && rd_pay == addr_a)
                                                           : (!rd_used && rd_bytes > r_req);
        o_stat.split_ok    = (r_cnt < CNT_MAX) &&
                             ({2'b0, rd_bytes} >= ({2'b0, r_req} + HDR34P1));
        o_stat.idx_zero    = (r_idx == '0);
        o_stat.next_in     = (idx_p1 < r_cnt);
        o_stat.up_more     = (r_j > idx_p1);
        o_stat.dn_more     = (j_p1 < r_cnt);
        o_stat.rd_free     = !rd_used;
    end

    always_comb begin
        case (i_cmd.rd_sel)
            ffha_pkg::RD_IDX_M1: rd_addr = idx_m1[IDX_W-1:0];
            ffha_pkg::RD_IDX_P1: rd_addr = idx_p1[IDX_W-1:0];
            ffha_pkg::RD_J_M1:   rd_addr = j_m1[IDX_W-1:0];
            ffha_pkg::RD_J_P1:   rd_addr = j_p1[IDX_W-1:0];
            default:             rd_addr = r_idx[IDX_W-1:0];
        endcase
    end

    // config write rebuilds the table as one free segment (an empty table when the size is below the header)
    assign n_base   = (i_cfg_idx == ffha_pkg::REG_BASE) ? i_cfg_data : r_base;
    assign n_size   = (i_cfg_idx == ffha_pkg::REG_SIZE) ? i_cfg_data : r_size;
    assign base_ext = {{A{1'b0}}, n_base};

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = {1'b0, r_cur_bytes, r_cur_start};
        if (i_cfg_we) begin
            wr_addr = '0;
            wr_data = {1'b0, n_size - HDR32, base_ext[A-1:0]};
        end else begin
            case (i_cmd.wr_sel)
                ffha_pkg::WR_SHIFT: begin
                    wr_addr = r_j[IDX_W-1:0];
                    wr_data = r_rdata;
                end
                ffha_pkg::WR_SPLIT_NEW: begin
                    wr_addr = idx_p1[IDX_W-1:0];
                    wr_data = {1'b0, r_cur_bytes - r_req - HDR32, cur_pay + req_a};
                end
                ffha_pkg::WR_SPLIT_OWN: wr_data = {1'b1, r_req, r_cur_start};
                ffha_pkg::WR_WHOLE:     wr_data = {1'b1, r_cur_bytes, r_cur_start};
                ffha_pkg::WR_FREE:      wr_data = {1'b0, r_cur_bytes, r_cur_start};
                default:                wr_en   = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_size <= '0;
            r_cnt  <= '0;
        end else if (i_cfg_we) begin
            r_base <= n_base;
            r_size <= n_size;
            r_cnt  <= (n_size < HDR32) ? CNT_W'(0) : CNT_W'(1);
        end else begin
            case (i_cmd.cnt_op)
                ffha_pkg::CNT_INC: r_cnt <= r_cnt + CNT_W'(1);
                ffha_pkg::CNT_DEC: r_cnt <= r_cnt - CNT_W'(1);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in.cmd;
            r_req  <= i_in.request_bytes;
            r_addr <= i_in.block_address;
            r_idx  <= '0;
        end else begin
            case (i_cmd.idx_op)
                ffha_pkg::IDX_INC: r_idx <= idx_p1;
                ffha_pkg::IDX_DEC: r_idx <= idx_m1;
                default: begin
                end
            endcase
        end
        case (i_cmd.j_op)
            ffha_pkg::J_CNT:    r_j <= r_cnt;
            ffha_pkg::J_IDX:    r_j <= r_idx;
            ffha_pkg::J_IDX_P1: r_j <= idx_p1;
            ffha_pkg::J_INC:    r_j <= j_p1;
            ffha_pkg::J_DEC:    r_j <= j_m1;
            default: begin
            end
        endcase
        case (i_cmd.cur_op)
            ffha_pkg::CUR_LOAD: begin
                r_cur_start <= rd_start;
                r_cur_bytes <= rd_bytes;
            end
            ffha_pkg::CUR_MERGE_PREV: begin
                r_cur_start <= rd_start;
                r_cur_bytes <= rd_bytes + r_cur_bytes + HDR32;
            end
            ffha_pkg::CUR_MERGE_NEXT: r_cur_bytes <= r_cur_bytes + rd_bytes + HDR32;
            default: begin
            end
        endcase
        case (i_cmd.res_op)
            ffha_pkg::RES_GRANT: begin
                r_out.granted_address <= pay_ext[31:0];
                r_out.status          <= ffha_pkg::ST_DONE;
            end
            ffha_pkg::RES_MISS: begin
                r_out.granted_address <= '0;
                r_out.status <= (r_cmd == ffha_pkg::CMD_FREE) ? ffha_pkg::ST_BAD_FREE
                                                              : ffha_pkg::ST_NO_FIT;
            end
            ffha_pkg::RES_OK: begin
                r_out.granted_address <= '0;
                r_out.status          <= ffha_pkg::ST_DONE;
            end
            default: begin
            end
        endcase
    end

    assign o_out = r_out;

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// each word scans the table entries up to the match (S_SCAN_RD, S_SCAN_CHK per entry), then
// moves every entry above the match (S_UP_RD, S_UP_WR) when a split inserts an entry, or
// every entry above it (S_DN_RD, S_DN_WR) when a merge removes one, besides the fixed steps
// one word at a time: start is taken only while busy is low; the result is held on o_out
// until the next result, with o_done high for one cycle, and cannot stall
// reset (synchronous, active low) empties the table at once; no clearing pass
module first_fit_heap_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 16,
    parameter int ADDR_BITS    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ffha_pkg::t_in_word  i_in,
    output logic                o_done,
    output ffha_pkg::t_out_word o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    ffha_pkg::t_dp_cmd  dp_cmd;
    ffha_pkg::t_dp_stat dp_stat;

    // sequencer: scan, shift up for a split, merge and shift down for a release
    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // segment table memory, counters, working entry and result register
    ffha_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .HEADER_BYTES (HEADER_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out      (o_out)
    );

    // one result strobe per word, then back to idle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held longer than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("not idle after result");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done)) else $error("accepted word not worked");

endmodule
